// ===== design/dsf_pkg.sv =====
`timescale 1ns / 1ps
package dsf_pkg;

   localparam int COORD_BITS_DEF      = 21;
   localparam int COORD_FRAC_BITS_DEF = 10;

   // unit direction component magnitude, Q.24 so at most 2^24
   localparam int UNIT_Q_BITS = 25;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SPRING_ENABLED  = 2'd0,
      CSR_SPRING_CONSTANT = 2'd1,
      CSR_DAMPING_COEFF   = 2'd2,
      CSR_REST_LENGTH     = 2'd3
   } csr_index_type;

   localparam logic        SPRING_ENABLED_RST  = 1'b1;
   localparam logic [31:0] SPRING_CONSTANT_RST = 32'h0001_0000;
   localparam logic [31:0] DAMPING_COEFF_RST   = 32'h0000_0000;
   localparam logic [30:0] REST_LENGTH_RST     = 31'h0000_0000;

   localparam int REQ_DATA_BITS = 256;
   localparam int RSP_DATA_BITS = 96;
   localparam int FIELD_BITS    = 63;

   // width of the line force before the per-axis product, saturated to +-2^38
   localparam int R_BITS = 40;

   typedef struct packed {
      logic act;
      logic a_free;
      logic b_free;
   } flags_type;

endpackage

// ===== design/dsf_delay.sv =====
`timescale 1ns / 1ps
module dsf_delay
   import dsf_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [WIDTH-1:0] d_i,
   output logic [WIDTH-1:0] q_o
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) tap_ff[i] <= '0;
      end else if (en) begin
         tap_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign q_o = tap_ff[DEPTH-1];

endmodule

// ===== design/dsf_isqrt.sv =====
`timescale 1ns / 1ps
module dsf_isqrt
   import dsf_pkg::*;
#(
   parameter int RW = 30
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*RW-1:0] x_i,
   output logic [RW-1:0]   root_o
);

   localparam int XW = 2 * RW;

   // one result bit per stage, restoring
   logic [RW+1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [XW-1:0] x_ff    [RW];
   logic [RW+1:0] rem_in  [RW];
   logic [RW-1:0] root_in [RW];
   logic [XW-1:0] x_in    [RW];
   logic [RW+1:0] rem_prev  [RW];
   logic [RW-1:0] root_prev [RW];
   logic [XW-1:0] x_prev    [RW];
   logic [RW+1:0] rem_sh    [RW];
   logic [RW+1:0] trial     [RW];
   logic          take      [RW];

   genvar k;
   for (k = 0; k < RW; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign rem_prev[k]  = '0;
         assign root_prev[k] = '0;
         assign x_prev[k]    = x_i;
      end else begin : g_next
         assign rem_prev[k]  = rem_ff[k-1];
         assign root_prev[k] = root_ff[k-1];
         assign x_prev[k]    = x_ff[k-1];
      end
      assign rem_sh[k]  = {rem_prev[k][RW-1:0], x_prev[k][XW-1 -: 2]};
      assign trial[k]   = {root_prev[k], 2'b01};
      assign take[k]    = (rem_sh[k] >= trial[k]);
      assign rem_in[k]  = take[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
      assign root_in[k] = {root_prev[k][RW-2:0], take[k]};
      assign x_in[k]    = x_prev[k] << 2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < RW; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            x_ff[i]    <= x_in[i];
         end
      end
   end

   assign root_o = root_ff[RW-1];

endmodule

// ===== design/dsf_div.sv =====
`timescale 1ns / 1ps
module dsf_div
   import dsf_pkg::*;
#(
   parameter int MW = 22,
   parameter int RW = 30
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [MW-1:0]          mag_i,
   input  logic [RW-1:0]          den_i,
   output logic [UNIT_Q_BITS-1:0] quo_o
);

   localparam int QW = UNIT_Q_BITS;

   // quotient of mag * 2^32 / den; remainder starts at mag * 2^7, then only zeros shift in
   logic [RW:0]   rem_ff  [QW];
   logic [RW-1:0] den_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [RW:0]   rem_in  [QW];
   logic [QW-1:0] quo_in  [QW];
   logic [RW:0]   rem_prev [QW];
   logic [RW-1:0] den_prev [QW];
   logic [QW-1:0] quo_prev [QW];
   logic [RW:0]   rem_sh   [QW];
   logic          take     [QW];

   genvar k;
   for (k = 0; k < QW; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign rem_prev[k] = (RW+1)'({mag_i, 7'd0});
         assign den_prev[k] = den_i;
         assign quo_prev[k] = '0;
      end else begin : g_next
         assign rem_prev[k] = rem_ff[k-1];
         assign den_prev[k] = den_ff[k-1];
         assign quo_prev[k] = quo_ff[k-1];
      end
      assign rem_sh[k] = {rem_prev[k][RW-1:0], 1'b0};
      assign take[k]   = (rem_sh[k] >= {1'b0, den_prev[k]});
      assign rem_in[k] = take[k] ? (rem_sh[k] - {1'b0, den_prev[k]}) : rem_sh[k];
      assign quo_in[k] = {quo_prev[k][QW-2:0], take[k]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QW; i++) begin
            rem_ff[i] <= rem_in[i];
            den_ff[i] <= (i == 0) ? den_i : den_ff[i == 0 ? 0 : i-1];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign quo_o = quo_ff[QW-1];

endmodule

// ===== design/dsf_smul.sv =====
`timescale 1ns / 1ps
module dsf_smul
   import dsf_pkg::*;
#(
   parameter int AW = 40,
   parameter int BW = 32
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [AW-1:0]       a_i,
   input  logic signed [BW-1:0]       b_i,
   output logic signed [AW+BW-1:0]    p_o
);

   localparam int L = AW / 2;
   localparam int H = AW - L;
   localparam int PW = AW + BW;

   // two partial products, summed in the second stage
   logic signed [L+BW:0]   lo_ff, lo_in;
   logic signed [H+BW-1:0] hi_ff, hi_in;
   logic signed [PW-1:0]   p_ff, p_in;
   logic signed [PW-1:0]   lo_x, hi_x;

   always_comb begin
      lo_in = $signed({1'b0, a_i[L-1:0]}) * b_i;
      hi_in = $signed(a_i[AW-1:L]) * b_i;
      lo_x  = PW'(lo_ff);
      hi_x  = PW'(hi_ff);
      p_in  = (hi_x <<< L) + lo_x;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         p_ff  <= p_in;
      end
   end

   assign p_o = p_ff;

endmodule

// ===== design/damped_spring_force_top.sv =====
`timescale 1ns / 1ps
// Damped Hooke spring between two particles in 3D. One spring is taken per clock
// unless the pipeline stalls, and its force on particle a leaves through the output
// register. The item passes COORD_BITS + 46 registers, the first loaded at the
// accepting edge: three input stages, one stage per root bit of the pipelined square
// root (COORD_BITS + 9), one stage per quotient bit of the three direction dividers
// (25), eight stages of multiply and saturate, then the output register. The output
// register holds a result while rsp_tready is low; the whole pipeline stalls with it,
// so req_tready follows rsp_tready once a result waits.
// Registers are written through csr_* and should only change while no item is in flight.
module damped_spring_force_top
   import dsf_pkg::*;
#(
   parameter int COORD_BITS      = COORD_BITS_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // pos_a, pos_b, vel_a, vel_b (63 each), zero fill
   input  logic [2:0]               req_tuser,  // a_free, b_free, b_present
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // force_x, force_y, force_z
   output logic [1:0]               rsp_tuser,  // add_to_a, add_to_b
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CW    = COORD_BITS;
   localparam int FB    = COORD_FRAC_BITS;
   localparam int DW    = CW + 1;
   localparam int RW    = CW + 9;
   localparam int XW    = 2 * RW;
   localparam int QW    = UNIT_Q_BITS;
   localparam int UW    = QW + 1;
   localparam int SRAW  = RW + 8 - FB;
   localparam int SW    = ((SRAW > 31) ? SRAW : 31) + 1;
   localparam int SPW   = SW + 32;
   localparam int VSW   = UW + DW + 2;
   localparam int VW    = VSW - FB - 8;
   localparam int DPW   = VW + 32;
   localparam int RSW   = ((SPW > DPW) ? SPW : DPW) - 16 + 3;
   localparam int FPW   = R_BITS + UW;
   localparam int SIDE1 = 3 + 6 * DW;
   localparam int SIDE2 = 3 + 3 * DW + 3 + RW;

   logic en;

   // configuration
   logic               spring_en_ff;
   logic signed [31:0] spring_k_ff;
   logic signed [31:0] damping_ff;
   logic [30:0]        rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spring_en_ff <= SPRING_ENABLED_RST;
         spring_k_ff  <= SPRING_CONSTANT_RST;
         damping_ff   <= DAMPING_COEFF_RST;
         rest_ff      <= REST_LENGTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPRING_ENABLED:  spring_en_ff <= csr_wdata[0];
            CSR_SPRING_CONSTANT: spring_k_ff  <= csr_wdata;
            CSR_DAMPING_COEFF:   damping_ff   <= csr_wdata;
            CSR_REST_LENGTH:     rest_ff      <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 1: component differences
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [DW-1:0] s1_diff_ff [3];
   logic signed [DW-1:0] s1_dvel_ff [3];
   logic signed [DW-1:0] s1_diff_in [3];
   logic signed [DW-1:0] s1_dvel_in [3];
   flags_type            s1_flags_ff, s1_flags_in;

   always_comb begin
      s1_valid_in = req_tvalid;
      for (int i = 0; i < 3; i++) begin
         s1_diff_in[i] = DW'($signed(req_tdata[i*CW +: CW]))
                       - DW'($signed(req_tdata[FIELD_BITS + i*CW +: CW]));
         s1_dvel_in[i] = DW'($signed(req_tdata[2*FIELD_BITS + i*CW +: CW]))
                       - DW'($signed(req_tdata[3*FIELD_BITS + i*CW +: CW]));
      end
      s1_flags_in.a_free = req_tuser[0];
      s1_flags_in.b_free = req_tuser[1];
      s1_flags_in.act    = spring_en_ff && req_tuser[2] && (req_tuser[0] || req_tuser[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_diff_ff  <= s1_diff_in;
         s1_dvel_ff  <= s1_dvel_in;
         s1_flags_ff <= s1_flags_in;
      end
   end

   // stages 2 and 3: squares, then their sum scaled by 2^16
   logic [2*DW-1:0] s2_sq_ff [3];
   logic [2*DW-1:0] s2_sq_in [3];
   logic [XW-1:0]   s3_x_ff, s3_x_in;
   logic [XW-17:0]  sq_sum;

   always_comb begin
      for (int i = 0; i < 3; i++) s2_sq_in[i] = s1_diff_ff[i] * s1_diff_ff[i];
      sq_sum  = (XW-16)'(s2_sq_ff[0]) + (XW-16)'(s2_sq_ff[1]) + (XW-16)'(s2_sq_ff[2]);
      s3_x_in = {sq_sum, 16'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sq_ff <= s2_sq_in;
         s3_x_ff  <= s3_x_in;
      end
   end

   logic [RW-1:0] distance;

   dsf_isqrt #(.RW(RW)) u_isqrt (
      .clock  (clock),
      .en     (en),
      .x_i    (s3_x_ff),
      .root_o (distance)
   );

   logic [SIDE1-1:0] side1_in, side1_out;
   logic             v1_out;

   assign side1_in = {s1_flags_ff, s1_dvel_ff[2], s1_dvel_ff[1], s1_dvel_ff[0],
                      s1_diff_ff[2], s1_diff_ff[1], s1_diff_ff[0]};

   dsf_delay #(.WIDTH(SIDE1), .DEPTH(RW + 2)) u_side1 (
      .clock (clock), .reset (reset), .en (en), .d_i (side1_in), .q_o (side1_out)
   );
   dsf_delay #(.WIDTH(1), .DEPTH(RW + 2)) u_vld1 (
      .clock (clock), .reset (reset), .en (en), .d_i (s1_valid_ff), .q_o (v1_out)
   );

   // direction dividers
   logic signed [DW-1:0] m_diff [3];
   logic [DW-1:0]        m_mag  [3];
   logic [2:0]           m_sign;
   logic [QW-1:0]        quo    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_diff[i] = $signed(side1_out[i*DW +: DW]);
         m_sign[i] = m_diff[i][DW-1];
         m_mag[i]  = m_sign[i] ? DW'(-m_diff[i]) : DW'(m_diff[i]);
      end
   end

   genvar g;
   for (g = 0; g < 3; g++) begin : g_div
      dsf_div #(.MW(DW), .RW(RW)) u_div (
         .clock (clock),
         .en    (en),
         .mag_i (m_mag[g]),
         .den_i (distance),
         .quo_o (quo[g])
      );
   end

   logic [SIDE2-1:0] side2_in, side2_out;
   logic             v2_out;

   assign side2_in = {side1_out[SIDE1-1 -: 3 + 3*DW], m_sign, distance};

   dsf_delay #(.WIDTH(SIDE2), .DEPTH(QW)) u_side2 (
      .clock (clock), .reset (reset), .en (en), .d_i (side2_in), .q_o (side2_out)
   );
   dsf_delay #(.WIDTH(1), .DEPTH(QW)) u_vld2 (
      .clock (clock), .reset (reset), .en (en), .d_i (v1_out), .q_o (v2_out)
   );

   // P1: signed unit components and stretch
   logic [RW-1:0]        d2_dist;
   logic [2:0]           d2_sign;
   logic [RW+16-FB-1:0]  d2_dsh;
   logic                 p1_valid_ff, p1_valid_in;
   logic signed [UW-1:0] p1_u_ff [3];
   logic signed [UW-1:0] p1_u_in [3];
   logic signed [DW-1:0] p1_dvel_ff [3];
   logic signed [DW-1:0] p1_dvel_in [3];
   logic signed [SW-1:0] p1_stretch_ff, p1_stretch_in;
   flags_type            p1_flags_ff, p1_flags_in;

   always_comb begin
      d2_dist = side2_out[RW-1:0];
      d2_sign = side2_out[RW +: 3];
      for (int i = 0; i < 3; i++) begin
         p1_dvel_in[i] = $signed(side2_out[RW + 3 + i*DW +: DW]);
         if (d2_dist == '0) begin
            p1_u_in[i] = '0;
         end else if (d2_sign[i]) begin
            p1_u_in[i] = -$signed({1'b0, quo[i]});
         end else begin
            p1_u_in[i] = $signed({1'b0, quo[i]});
         end
      end
      p1_flags_in   = side2_out[SIDE2-1 -: 3];
      p1_valid_in   = v2_out;
      d2_dsh        = (RW+16-FB)'(d2_dist) << (16 - FB);
      p1_stretch_in = $signed(SW'(d2_dsh[RW+16-FB-1:8])) - $signed(SW'(rest_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_u_ff       <= p1_u_in;
         p1_dvel_ff    <= p1_dvel_in;
         p1_stretch_ff <= p1_stretch_in;
         p1_flags_ff   <= p1_flags_in;
      end
   end

   // P2, P3: closing speed products and their sum
   logic signed [UW+DW-1:0] p2_prod_ff [3];
   logic signed [UW+DW-1:0] p2_prod_in [3];
   logic signed [VSW-1:0]   p3_vsum_ff, p3_vsum_in;
   logic signed [VW-1:0]    p3_v;

   always_comb begin
      for (int i = 0; i < 3; i++) p2_prod_in[i] = p1_u_ff[i] * p1_dvel_ff[i];
      p3_vsum_in = VSW'(p2_prod_ff[0]) + VSW'(p2_prod_ff[1]) + VSW'(p2_prod_ff[2]);
      p3_v       = VW'(p3_vsum_ff >>> (FB + 8));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_prod_ff <= p2_prod_in;
         p3_vsum_ff <= p3_vsum_in;
      end
   end

   logic signed [SPW-1:0] spring_p3, spring_p5;
   logic signed [DPW-1:0] damp_p5;

   dsf_smul #(.AW(SW), .BW(32)) u_mul_spring (
      .clock (clock), .en (en), .a_i (p1_stretch_ff), .b_i (spring_k_ff), .p_o (spring_p3)
   );
   dsf_smul #(.AW(VW), .BW(32)) u_mul_damp (
      .clock (clock), .en (en), .a_i (p3_v), .b_i (damping_ff), .p_o (damp_p5)
   );
   dsf_delay #(.WIDTH(SPW), .DEPTH(2)) u_spring_dly (
      .clock (clock), .reset (reset), .en (en), .d_i (spring_p3), .q_o (spring_p5)
   );

   // P6: line force, saturated to +-2^38
   localparam logic signed [RSW-1:0] R_HI = RSW'(64'sd1 <<< 38);
   localparam logic signed [RSW-1:0] R_LO = -R_HI;

   logic signed [RSW-1:0]    r_sum;
   logic signed [R_BITS-1:0] p6_r_ff, p6_r_in;

   always_comb begin
      r_sum = -RSW'(spring_p5 >>> 16) - RSW'(damp_p5 >>> 16);
      if (r_sum > R_HI) begin
         p6_r_in = R_BITS'(R_HI);
      end else if (r_sum < R_LO) begin
         p6_r_in = R_BITS'(R_LO);
      end else begin
         p6_r_in = R_BITS'(r_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (en) p6_r_ff <= p6_r_in;
   end

   logic [3*UW-1:0]        u_p6_flat;
   logic signed [FPW-1:0]  fprod [3];

   dsf_delay #(.WIDTH(3 * UW), .DEPTH(5)) u_unit_dly (
      .clock (clock), .reset (reset), .en (en),
      .d_i ({p1_u_ff[2], p1_u_ff[1], p1_u_ff[0]}), .q_o (u_p6_flat)
   );

   for (g = 0; g < 3; g++) begin : g_fmul
      dsf_smul #(.AW(R_BITS), .BW(UW)) u_mul_force (
         .clock (clock),
         .en    (en),
         .a_i   (p6_r_ff),
         .b_i   ($signed(u_p6_flat[g*UW +: UW])),
         .p_o   (fprod[g])
      );
   end

   logic [3:0] p8_ctl;

   dsf_delay #(.WIDTH(4), .DEPTH(7)) u_ctl_dly (
      .clock (clock), .reset (reset), .en (en),
      .d_i ({p1_valid_ff, p1_flags_ff}), .q_o (p8_ctl)
   );

   // output register
   localparam int FSW = FPW - 24;
   localparam logic signed [FSW-1:0] F_HI = FSW'(64'sd2147483647);
   localparam logic signed [FSW-1:0] F_LO = FSW'(-64'sd2147483648);

   flags_type                p8_flags;
   logic signed [FSW-1:0]    fsh [3];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_user_ff, rsp_user_in;

   always_comb begin
      p8_flags     = p8_ctl[2:0];
      rsp_valid_in = p8_ctl[3];
      rsp_data_in  = '0;
      for (int i = 0; i < 3; i++) begin
         fsh[i] = FSW'(fprod[i] >>> 24);
         if (!p8_flags.act) begin
            rsp_data_in[i*32 +: 32] = '0;
         end else if (fsh[i] > F_HI) begin
            rsp_data_in[i*32 +: 32] = 32'h7FFF_FFFF;
         end else if (fsh[i] < F_LO) begin
            rsp_data_in[i*32 +: 32] = 32'h8000_0000;
         end else begin
            rsp_data_in[i*32 +: 32] = fsh[i][31:0];
         end
      end
      rsp_user_in = {p8_flags.act & p8_flags.b_free, p8_flags.act & p8_flags.a_free};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // both flags clear only when the spring is inactive, and then the force is zero
   a_idle_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_user_ff == 2'b00) |-> (rsp_data_ff == '0))
      else $error("inactive spring gave a non-zero force");

   a_unit_bound : assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> (p1_u_ff[0] <= $signed(UW'(1 << 24)))
                   && (p1_u_ff[0] >= -$signed(UW'(1 << 24))))
      else $error("unit component out of range");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(p1_valid_ff) && $stable(s1_valid_ff))
      else $error("pipeline moved during a stall");

   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !p1_valid_ff)
      else $error("valid bits not cleared by reset");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import dsf_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 300;
   localparam longint R_SAT   = 64'sd1 << 38;

   typedef struct {
      logic [31:0] fx, fy, fz;
      logic        add_a, add_b;
   } force_type;

   typedef struct {
      logic [62:0] pa, pb, va, vb;
      logic [2:0]  flags;     // a_free, b_free, b_present
      bit          known;
      force_type   res;
   } row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [2:0]               req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]               rsp_tuser;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // shadow copy of the registers
   bit     cfg_enabled;
   longint cfg_stiffness, cfg_damping, cfg_rest;

   force_type force_due[$];
   int     mismatches = 0;
   int     items_sent = 0;
   int     items_seen = 0;
   int     cycles = 0;
   bit     no_idle = 1'b0;

   damped_spring_force_top u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycles, force_due.size());
         $display("damped_spring_force_top verification failed");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, b;
      root = 0;
      b = 64'h1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= root + b) begin
            x = x - root - b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // exact floor(a * b / 2^s)
   function automatic longint mul_floor(longint a, longint b, int s);
      logic signed [127:0] pa, pb, prod;
      pa = a;
      pb = b;
      prod = (pa * pb) >>> s;
      return prod[63:0];
   endfunction

   function automatic longint axis(logic [62:0] w, int i);
      logic signed [20:0] c;
      c = w[i*21 +: 21];
      return c;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic force_type spring_force(logic [251:0] d, logic [2:0] u);
      force_type f;
      longint dif[3], dv[3], un[3];
      longint vsum, stretch, spring, damp, r, fc[3];
      longint unsigned sumsq, distance;
      f = '{default: '0};
      if (!cfg_enabled || !u[2] || !(u[0] | u[1])) return f;
      sumsq = 0;
      vsum = 0;
      for (int i = 0; i < 3; i++) begin
         dif[i] = axis(d[62:0], i) - axis(d[125:63], i);
         dv[i]  = axis(d[188:126], i) - axis(d[251:189], i);
         sumsq += dif[i] * dif[i];
      end
      distance = int_sqrt(sumsq << 16);
      for (int i = 0; i < 3; i++) begin
         un[i] = (distance == 0) ? 0 : (dif[i] * 64'sd4294967296) / longint'(distance);
         vsum += un[i] * dv[i];
      end
      stretch = (longint'(distance << 6) - cfg_rest * 256) >>> 8;
      spring = -mul_floor(stretch, cfg_stiffness, 16);
      damp = -mul_floor(vsum >>> 18, cfg_damping, 16);
      r = clamp(spring + damp, -R_SAT, R_SAT);
      for (int i = 0; i < 3; i++)
         fc[i] = clamp(mul_floor(r, un[i], 24), -64'sd2147483648, 64'sd2147483647);
      f.fx = fc[0][31:0];
      f.fy = fc[1][31:0];
      f.fz = fc[2][31:0];
      f.add_a = u[0];
      f.add_b = u[1];
      return f;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("item %0d: %s got %h want %h", items_seen, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (force_due.size() == 0) begin
            report("unexpected item", rsp_tdata[31:0], 32'h0);
         end else begin
            force_type w;
            w = force_due.pop_front();
            if (rsp_tdata[31:0] !== w.fx) report("force_x", rsp_tdata[31:0], w.fx);
            if (rsp_tdata[63:32] !== w.fy) report("force_y", rsp_tdata[63:32], w.fy);
            if (rsp_tdata[95:64] !== w.fz) report("force_z", rsp_tdata[95:64], w.fz);
            if (rsp_tuser[0] !== w.add_a)
               report("add_to_a", 32'(rsp_tuser[0]), 32'(w.add_a));
            if (rsp_tuser[1] !== w.add_b)
               report("add_to_b", 32'(rsp_tuser[1]), 32'(w.add_b));
         end
         items_seen++;
      end
   end

   // receiver back-pressure
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic send_item(row_type row);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_tdata <= {4'b0, row.vb, row.va, row.pb, row.pa};
      req_tuser <= row.flags;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      force_due.push_back(row.known ? row.res :
                          spring_force({row.vb, row.va, row.pb, row.pa}, row.flags));
      items_sent++;
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SPRING_ENABLED:  cfg_enabled = val[0];
         CSR_SPRING_CONSTANT: cfg_stiffness = longint'(signed'(val));
         CSR_DAMPING_COEFF:   cfg_damping = longint'(signed'(val));
         CSR_REST_LENGTH:     cfg_rest = val[30:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (force_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [62:0] pack3(logic [20:0] x, logic [20:0] y, logic [20:0] z);
      return {z, y, x};
   endfunction

   // component scaled down by a random shift so all distance ranges occur
   function automatic logic [20:0] rand_axis();
      logic signed [20:0] c;
      c = 21'($urandom);
      return c >>> $urandom_range(0, 20);
   endfunction

   function automatic logic [62:0] rand_vec();
      return pack3(rand_axis(), rand_axis(), rand_axis());
   endfunction

   function automatic row_type rand_row();
      row_type row;
      row.known = 1'b0;
      row.pa = rand_vec();
      row.va = rand_vec();
      row.vb = rand_vec();
      case ($urandom_range(0, 7))
         0: row.pb = row.pa;
         1: row.pb = pack3(21'(row.pa[20:0] + $urandom_range(0, 7) - 3),
                           21'(row.pa[41:21] + $urandom_range(0, 7) - 3),
                           21'(row.pa[62:42] + $urandom_range(0, 7) - 3));
         2: begin
            row.pa = 63'({$urandom, $urandom});
            row.pb = 63'({$urandom, $urandom});
         end
         default: row.pb = rand_vec();
      endcase
      // mostly live springs, the rest noise on the flags
      row.flags = ($urandom_range(0, 6) == 0) ? 3'($urandom) : {1'b1, 2'($urandom_range(1, 3))};
      return row;
   endfunction

   row_type   table_rows[$];
   force_type zero_force;

   initial begin
      row_type row;
      longint cfg_sets[6][4];
      cfg_enabled = SPRING_ENABLED_RST;
      cfg_stiffness = longint'(signed'(SPRING_CONSTANT_RST));
      cfg_damping = longint'(signed'(DAMPING_COEFF_RST));
      cfg_rest = REST_LENGTH_RST;
      zero_force = '{default: '0};
      cfg_sets = '{
         '{1, 65536, 65536, 0},
         '{1, -2147483648, 2147483647, 2147483647},
         '{1, 2147483647, -2147483648, 0},
         '{0, 12345, -999, 4096},
         '{1, 0, 0, 0},
         '{1, 98304, -32768, 131072}
      };

      // unit along x, stiffness 1.0 from reset: pulled back with 1.0
      row = '{pack3(21'd1024, 0, 0), '0, '0, '0, 3'b111, 1'b1,
              '{32'hFFFF_0000, 0, 0, 1'b1, 1'b1}};
      table_rows.push_back(row);
      row = '{pack3(0, 21'd1024, 0), '0, '0, '0, 3'b101, 1'b1,
              '{0, 32'hFFFF_0000, 0, 1'b1, 1'b0}};
      table_rows.push_back(row);
      row = '{pack3(0, 0, 21'h1FFC00), '0, '0, '0, 3'b110, 1'b1,
              '{0, 0, 32'h0001_0000, 1'b0, 1'b1}};
      table_rows.push_back(row);
      // coincident: no direction, flags still pass
      row = '{pack3(21'd77, 21'd5, 21'h1FFFF0), pack3(21'd77, 21'd5, 21'h1FFFF0),
              rand_vec(), rand_vec(), 3'b111, 1'b1, '{0, 0, 0, 1'b1, 1'b1}};
      table_rows.push_back(row);
      // b absent, then b present but neither free
      row = '{rand_vec(), rand_vec(), rand_vec(), rand_vec(), 3'b011, 1'b1, zero_force};
      table_rows.push_back(row);
      row = '{rand_vec(), rand_vec(), rand_vec(), rand_vec(), 3'b100, 1'b1, zero_force};
      table_rows.push_back(row);
      row = '{{3{21'h0FFFFF}}, {3{21'h100000}}, {3{21'h0FFFFF}}, {3{21'h100000}},
              3'b111, 1'b0, zero_force};
      table_rows.push_back(row);
      row = '{{3{21'h100000}}, {3{21'h0FFFFF}}, {3{21'h100000}}, {3{21'h0FFFFF}},
              3'b111, 1'b0, zero_force};
      table_rows.push_back(row);
      row = '{'1, '0, '1, '0, 3'b111, 1'b0, zero_force};
      table_rows.push_back(row);
      row = '{pack3(21'd1, 0, 0), '0, '1, '1, 3'b111, 1'b0, zero_force};
      table_rows.push_back(row);
      row = '{pack3(21'd3, 21'h1FFFFE, 21'd1), pack3(21'h1FFFFF, 0, 0),
              pack3(21'd500, 21'd9, 21'h1FFF00), '0, 3'b111, 1'b0, zero_force};
      table_rows.push_back(row);

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) send_item(table_rows[i]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_row());
      drain();

      for (int p = 0; p < 6; p++) begin
         csr_write(CSR_SPRING_ENABLED, 32'(cfg_sets[p][0]));
         csr_write(CSR_SPRING_CONSTANT, 32'(cfg_sets[p][1]));
         csr_write(CSR_DAMPING_COEFF, 32'(cfg_sets[p][2]));
         csr_write(CSR_REST_LENGTH, 32'(cfg_sets[p][3]));
         @(negedge clock);
         csr_we <= 1'b0;
         no_idle = (p == 1 || p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_row());
         drain();
      end

      $display("%0d springs sent, %0d forces checked over 7 register settings",
               items_sent, items_seen);
      if (mismatches == 0)
         $display("damped_spring_force_top verification clean");
      else
         $display("damped_spring_force_top verification failed");
      $finish;
   end

endmodule
